@@ hdl/vt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package vt_pkg;

  localparam int unsigned NumCfg   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned DivSteps = 32;

  localparam logic [63:0] CfgReset [NumCfg] = '{
    64'd65536, 64'd0, 64'd281474976710656, 64'd0,
    64'd0, 64'd65536, 64'd0, 64'd281474976710656
  };

  localparam logic [31:0] QMax = 32'h7FFF_FFFF;
  localparam logic [31:0] QMin = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic               divide_by_w;
  } vt_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               zero_w;
    logic               saturated;
  } vt_out_t;

  // One quotient lane of the divide pipeline plus what the final select needs.
  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] quo;
    logic [31:0] bits;
    logic [31:0] aff;
    logic        aff_sat;
    logic        s_zero;
    logic        s_neg;
    logic        big;
  } vt_lane_t;

  typedef struct packed {
    vt_lane_t [2:0] lane;
    logic [63:0]    den;
    logic           w_neg;
    logic           zw;
    logic           div;
  } vt_div_t;

endpackage
`default_nettype wire

@@ hdl/vertex_transform_4x4.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one item per cycle while the output is not stalled; the perspective divide is a
// 32-stage restoring divider pipeline, one quotient bit per stage, three lanes side by side.
// Empty stages close up while the output is stalled, so input keeps flowing until the pipeline is full.
// Reset (rst_ni low, asynchronous) empties the pipeline and loads the identity matrix.
module vertex_transform_4x4 (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire vt_pkg::vt_in_t             in_data_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output vt_pkg::vt_out_t                 out_data_o,
  input  wire logic                       cfg_we_i,
  input  wire logic [vt_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [63:0]                cfg_data_i
);

  logic [63:0] cfg_q [vt_pkg::NumCfg];

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < vt_pkg::NumCfg; i++) cfg_q[i] <= vt_pkg::CfgReset[i];
    end else if (cfg_we_i) begin
      cfg_q[cfg_idx_i] <= cfg_data_i;
    end
  end

  // Matrix element view: row r, column c.
  logic signed [31:0] m [4][4];
  always_comb begin
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 4; c++) begin
        m[r][c] = (c % 2 == 1) ? cfg_q[2*r + c/2][63:32] : cfg_q[2*r + c/2][31:0];
      end
    end
  end

  // Flow control: a stage loads whenever it is empty or its item moves on.
  logic out_free, s1_free, s2_free, s3_free;
  logic dfree [vt_pkg::DivSteps+1];
  logic s1_v_q, s2_v_q, s3_v_q, out_v_q;
  logic vd_q [vt_pkg::DivSteps+1];

  assign out_free = !out_v_q || !out_stall_i;
  assign dfree[vt_pkg::DivSteps] = !vd_q[vt_pkg::DivSteps] || out_free;
  for (genvar k = 0; k < vt_pkg::DivSteps; k++) begin : g_free
    assign dfree[k] = !vd_q[k] || dfree[k+1];
  end
  assign s3_free = !s3_v_q || dfree[0];
  assign s2_free = !s2_v_q || s3_free;
  assign s1_free = !s1_v_q || s2_free;
  assign in_stall_o = !s1_free;

  // Stage 1: the twelve products, exact in Q32.32.
  logic signed [63:0] prod_q [4][3];
  logic               s1_div_q;
  always_ff @(posedge clk_i) begin
    if (s1_free) begin
      for (int c = 0; c < 4; c++) begin
        prod_q[c][0] <= in_data_i.point_x * m[0][c];
        prod_q[c][1] <= in_data_i.point_y * m[1][c];
        prod_q[c][2] <= in_data_i.point_z * m[2][c];
      end
      s1_div_q <= in_data_i.divide_by_w;
    end
  end

  // Stage 2: column sums plus translation.
  logic signed [65:0] sum_q [4];
  logic               s2_div_q;
  always_ff @(posedge clk_i) begin
    if (s2_free) begin
      for (int c = 0; c < 4; c++) begin
        sum_q[c] <= 66'(prod_q[c][0]) + 66'(prod_q[c][1]) + 66'(prod_q[c][2])
                  + (66'(m[3][c]) <<< 16);
      end
      s2_div_q <= s1_div_q;
    end
  end

  // Stage 3: magnitudes, signs and the rounding add for the affine path.
  logic [63:0]        mag_q [4];
  logic               neg_q [4];
  logic               zero_q [4];
  logic signed [65:0] rnd_q [3];
  logic               s3_div_q;
  always_ff @(posedge clk_i) begin
    if (s3_free) begin
      for (int c = 0; c < 4; c++) begin
        mag_q[c]  <= sum_q[c][65] ? 64'(-sum_q[c]) : sum_q[c][63:0];
        neg_q[c]  <= sum_q[c][65];
        zero_q[c] <= (sum_q[c] == '0);
      end
      for (int c = 0; c < 3; c++) rnd_q[c] <= sum_q[c] + 66'sd32768;
      s3_div_q <= s2_div_q;
    end
  end

  // Stage 4: affine saturation, divider overflow check, divider setup.
  vt_pkg::vt_div_t st_q [vt_pkg::DivSteps+1];
  vt_pkg::vt_div_t st0_d;
  always_comb begin
    logic [49:0] sh;
    logic        fits;
    st0_d       = '0;
    st0_d.den   = mag_q[3];
    st0_d.w_neg = neg_q[3];
    st0_d.div   = s3_div_q;
    st0_d.zw    = s3_div_q && zero_q[3];
    for (int c = 0; c < 3; c++) begin
      sh   = rnd_q[c][65:16];
      fits = (&sh[49:31]) || !(|sh[49:31]);
      st0_d.lane[c].aff     = fits ? sh[31:0] : (sh[49] ? vt_pkg::QMin : vt_pkg::QMax);
      st0_d.lane[c].aff_sat = !fits;
      st0_d.lane[c].s_zero  = zero_q[c];
      st0_d.lane[c].s_neg   = neg_q[c];
      st0_d.lane[c].big     = {16'h0, mag_q[c]} >= {mag_q[3], 16'h0};
      st0_d.lane[c].rem     = {16'h0, mag_q[c][63:16]};
      st0_d.lane[c].bits    = {mag_q[c][15:0], 16'h0};
      st0_d.lane[c].quo     = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (dfree[0]) st_q[0] <= st0_d;
  end

  // Divider stages: one restoring step per stage on each lane.
  for (genvar k = 0; k < vt_pkg::DivSteps; k++) begin : g_div
    vt_pkg::vt_div_t nx;
    always_comb begin
      logic [64:0] t;
      logic        ge;
      nx = st_q[k];
      for (int c = 0; c < 3; c++) begin
        t  = {st_q[k].lane[c].rem, st_q[k].lane[c].bits[31]};
        ge = t >= {1'b0, st_q[k].den};
        nx.lane[c].rem  = ge ? 64'(t - {1'b0, st_q[k].den}) : t[63:0];
        nx.lane[c].quo  = {st_q[k].lane[c].quo[30:0], ge};
        nx.lane[c].bits = {st_q[k].lane[c].bits[30:0], 1'b0};
      end
    end
    always_ff @(posedge clk_i) begin
      if (dfree[k+1]) st_q[k+1] <= nx;
    end
  end

  // Valid bits travel with the items.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
      for (int k = 0; k <= vt_pkg::DivSteps; k++) vd_q[k] <= 1'b0;
    end else begin
      if (s1_free) s1_v_q <= in_valid_i;
      if (s2_free) s2_v_q <= s1_v_q;
      if (s3_free) s3_v_q <= s2_v_q;
      if (dfree[0]) vd_q[0] <= s3_v_q;
      for (int k = 0; k < vt_pkg::DivSteps; k++) begin
        if (dfree[k+1]) vd_q[k+1] <= vd_q[k];
      end
      if (out_free) out_v_q <= vd_q[vt_pkg::DivSteps];
    end
  end

  // Final select: affine, zero w, or signed and saturated quotient.
  vt_pkg::vt_out_t out_d, out_q;
  always_comb begin
    vt_pkg::vt_div_t f;
    logic [31:0]     r [3];
    logic            sat;
    logic            ng;
    f   = st_q[vt_pkg::DivSteps];
    sat = 1'b0;
    for (int c = 0; c < 3; c++) begin
      ng = f.lane[c].s_neg != f.w_neg;
      if (!f.div) begin
        r[c] = f.lane[c].aff;
        sat  = sat | f.lane[c].aff_sat;
      end else if (f.zw) begin
        r[c] = f.lane[c].s_zero ? 32'h0 : (f.lane[c].s_neg ? vt_pkg::QMin : vt_pkg::QMax);
        sat  = sat | !f.lane[c].s_zero;
      end else if (f.lane[c].s_zero) begin
        r[c] = 32'h0;
      end else if (ng) begin
        if (f.lane[c].big || f.lane[c].quo > vt_pkg::QMin) begin
          r[c] = vt_pkg::QMin;
          sat  = 1'b1;
        end else begin
          r[c] = 32'h0 - f.lane[c].quo;
        end
      end else begin
        if (f.lane[c].big || f.lane[c].quo > vt_pkg::QMax) begin
          r[c] = vt_pkg::QMax;
          sat  = 1'b1;
        end else begin
          r[c] = f.lane[c].quo;
        end
      end
    end
    out_d.out_x     = r[0];
    out_d.out_y     = r[1];
    out_d.out_z     = r[2];
    out_d.zero_w    = f.zw;
    out_d.saturated = sat;
  end

  always_ff @(posedge clk_i) begin
    if (out_free) out_q <= out_d;
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // A zero w result that is not flagged saturated must be all zero.
  a_zw_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_q.zero_w && !out_q.saturated |->
      out_q.out_x == 0 && out_q.out_y == 0 && out_q.out_z == 0)
    else $error("zero w result without saturation is not zero");

  // With the output side open, the whole pipeline moves and input is taken.
  a_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output is not stalled");

  // An item in the last divider stage is kept while it cannot move on.
  a_hold_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    vd_q[vt_pkg::DivSteps] && !out_free |=> vd_q[vt_pkg::DivSteps])
    else $error("item lost in last divider stage");

endmodule
`default_nettype wire

@@ test/vertex_transform_4x4_test.sv @@
`timescale 1ns / 1ps
module vertex_transform_4x4_test;

  localparam int unsigned Latency    = 36;
  localparam int unsigned StallLimit = 4000;
  localparam logic signed [95:0] SumMax = 96'sh7FFF_FFFF;
  localparam logic signed [95:0] SumMin = -96'sh8000_0000;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_stall;
  vt_pkg::vt_in_t  in_data = '0;
  logic            out_valid;
  logic            out_stall = 1'b0;
  vt_pkg::vt_out_t out_data;
  logic            cfg_we = 1'b0;
  logic [vt_pkg::CfgIdxW-1:0] cfg_idx = '0;
  logic [63:0]     cfg_data = '0;

  // Mirror of the matrix registers, used by the predictor.
  logic [63:0]     matrix_reg [vt_pkg::NumCfg];
  vt_pkg::vt_in_t  point_queue [$];
  vt_pkg::vt_out_t expected_points [$];
  int unsigned     mismatches = 0;
  int unsigned     send_gap = 0;
  int unsigned     stall_left = 0;
  int unsigned     quiet_cycles = 0;
  logic            no_idling = 1'b0;

  vertex_transform_4x4 uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Clock; the single reset at the start is released by the main sequence.
  initial begin
    forever #2 clk = ~clk;
  end

  // Matrix element M[r][c] as signed Q16.16.
  function automatic logic signed [31:0] mat_elem(int r, int c);
    logic [63:0] word;
    word = matrix_reg[r * 2 + c / 2];
    return (c % 2) ? word[63:32] : word[31:0];
  endfunction

  // Exact Q32.32 sum of one column for the row vector (x, y, z, 1).
  function automatic logic signed [95:0] column_sum(vt_pkg::vt_in_t p, int c);
    logic signed [95:0] acc;
    logic signed [95:0] a;
    logic signed [95:0] b;
    a = p.point_x; b = mat_elem(0, c); acc = a * b;
    a = p.point_y; b = mat_elem(1, c); acc = acc + a * b;
    a = p.point_z; b = mat_elem(2, c); acc = acc + a * b;
    b = mat_elem(3, c);
    acc = acc + b * 96'sd65536;
    return acc;
  endfunction

  // Round to nearest (ties up) to Q16.16 and clamp.
  function automatic logic [31:0] round_clamp(logic signed [95:0] s, ref logic sat);
    logic signed [95:0] r;
    r = (s + 96'sd32768) >>> 16;
    if (r > SumMax) begin
      sat = 1'b1;
      return vt_pkg::QMax;
    end
    if (r < SumMin) begin
      sat = 1'b1;
      return vt_pkg::QMin;
    end
    return r[31:0];
  endfunction

  // Truncating quotient s / w in Q16.16, clamped.
  function automatic logic [31:0] divide_clamp(logic signed [95:0] s, logic signed [95:0] w,
                                              ref logic sat);
    logic [127:0] n;
    logic [127:0] d;
    logic [127:0] q;
    logic         neg;
    if (s == 0) return 32'd0;
    neg = (s < 0) != (w < 0);
    n = (s < 0) ? 128'(-s) : 128'(s);
    d = (w < 0) ? 128'(-w) : 128'(w);
    q = (n << 16) / d;
    if (neg) begin
      if (q > 128'h8000_0000) begin
        sat = 1'b1;
        return vt_pkg::QMin;
      end
      return 32'd0 - q[31:0];
    end
    if (q > 128'h7FFF_FFFF) begin
      sat = 1'b1;
      return vt_pkg::QMax;
    end
    return q[31:0];
  endfunction

  function automatic vt_pkg::vt_out_t transform_point(vt_pkg::vt_in_t p);
    vt_pkg::vt_out_t    o;
    logic signed [95:0] w;
    logic signed [95:0] s;
    logic [31:0]        comp [3];
    logic               sat;
    logic               zw;
    sat = 1'b0;
    w = column_sum(p, 3);
    zw = p.divide_by_w && (w == 0);
    for (int c = 0; c < 3; c++) begin
      s = column_sum(p, c);
      if (!p.divide_by_w) begin
        comp[c] = round_clamp(s, sat);
      end else if (zw) begin
        if (s == 0) begin
          comp[c] = 32'd0;
        end else begin
          sat = 1'b1;
          comp[c] = (s < 0) ? vt_pkg::QMin : vt_pkg::QMax;
        end
      end else begin
        comp[c] = divide_clamp(s, w, sat);
      end
    end
    o.out_x = comp[0];
    o.out_y = comp[1];
    o.out_z = comp[2];
    o.zero_w = zw;
    o.saturated = sat;
    return o;
  endfunction

  // Driver: sends queued points with random gaps, holds a stalled item.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_points.push_back(transform_point(in_data));
        void'(point_queue.pop_front());
      end
      if (in_valid && in_stall) begin
        // Hold the item until it is taken.
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (point_queue.size() > 0) begin
        if (!no_idling && $urandom_range(0, 7) == 0) begin
          send_gap <= $urandom_range(1, 9) - 1;
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_data <= point_queue[0];
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: random output stalls and field-by-field compare.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_points.size() == 0) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("unexpected result %h", out_data);
        end else begin
          vt_pkg::vt_out_t want;
          want = expected_points.pop_front();
          if (want.out_x !== out_data.out_x || want.out_y !== out_data.out_y ||
              want.out_z !== out_data.out_z || want.zero_w !== out_data.zero_w ||
              want.saturated !== out_data.saturated) begin
            mismatches <= mismatches + 1;
            if (mismatches < 10)
              $display({"mismatch: expected x=%h y=%h z=%h zw=%b sat=%b, ",
                        "got x=%h y=%h z=%h zw=%b sat=%b"},
                       want.out_x, want.out_y, want.out_z, want.zero_w, want.saturated,
                       out_data.out_x, out_data.out_y, out_data.out_z, out_data.zero_w,
                       out_data.saturated);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (!no_idling && $urandom_range(0, 7) == 0) begin
        stall_left <= $urandom_range(1, 9) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles in which no item moves on either side.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit) begin
          $display("TB_ERROR");
          $finish;
        end
      end
    end
  end

  task automatic write_reg(int idx, logic [63:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx[vt_pkg::CfgIdxW-1:0];
    cfg_data <= value;
    matrix_reg[idx] = value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Writes all eight registers from sixteen elements in row-major order.
  task automatic load_matrix(logic [31:0] m [16]);
    for (int i = 0; i < vt_pkg::NumCfg; i++) write_reg(i, {m[2 * i + 1], m[2 * i]});
  endtask

  task automatic queue_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic dw);
    vt_pkg::vt_in_t p;
    p.point_x = x;
    p.point_y = y;
    p.point_z = z;
    p.divide_by_w = dw;
    point_queue.push_back(p);
  endtask

  // Coordinates are mostly moderate so that results do not all clamp.
  function automatic logic [31:0] rand_coord();
    if ($urandom_range(0, 3) == 0) return $urandom;
    return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
  endfunction

  function automatic logic [31:0] rand_elem();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'd0;
      default: return 32'($urandom_range(0, 32'h0008_0000)) - 32'h0004_0000;
    endcase
  endfunction

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++)
      queue_point(rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
  endtask

  // Waits for all items to be taken and every result to come back.
  task automatic drain();
    while (point_queue.size() > 0 || in_valid || expected_points.size() > 0) @(posedge clk);
    repeat (Latency + 3) @(posedge clk);
  endtask

  initial begin
    logic [31:0] m [16];
    for (int i = 0; i < vt_pkg::NumCfg; i++) matrix_reg[i] = vt_pkg::CfgReset[i];
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed points under the reset identity matrix.
    queue_point(32'd0, 32'd0, 32'd0, 1'b0);
    queue_point(vt_pkg::QMax, vt_pkg::QMax, vt_pkg::QMax, 1'b0);
    queue_point(vt_pkg::QMin, vt_pkg::QMin, vt_pkg::QMin, 1'b0);
    queue_point(vt_pkg::QMax, vt_pkg::QMin, 32'h0001_0000, 1'b1);
    queue_point(32'hFFFF_FFFF, 32'h0000_0001, 32'h1234_5678, 1'b1);
    queue_point(vt_pkg::QMin, vt_pkg::QMax, 32'd0, 1'b1);
    drain();

    // Perspective matrix: w equals z, so z of zero gives a zero w.
    m = '{default: 32'd0};
    m[0] = 32'h0001_0000; m[5] = 32'h0001_0000; m[10] = 32'h0001_0000; m[11] = 32'h0001_0000;
    load_matrix(m);
    queue_point(32'h0001_0000, 32'hFFFF_0000, 32'd0, 1'b1);
    queue_point(32'd0, 32'd0, 32'd0, 1'b1);
    queue_point(32'h0003_0000, 32'h0002_0000, 32'h0002_0000, 1'b1);
    queue_point(32'h0003_0000, 32'hFFFD_0000, 32'hFFFE_0000, 1'b1);
    queue_point(vt_pkg::QMax, vt_pkg::QMin, 32'h0000_0001, 1'b1);
    queue_point(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0003, 1'b1);
    queue_point(vt_pkg::QMax, 32'd5, vt_pkg::QMin, 1'b1);
    queue_point(32'h0001_0000, 32'h0001_0000, 32'd0, 1'b0);
    drain();

    // Matrix extremes: all positive limits, then all negative limits.
    m = '{default: vt_pkg::QMax};
    load_matrix(m);
    queue_point(vt_pkg::QMax, vt_pkg::QMax, vt_pkg::QMax, 1'b0);
    queue_point(vt_pkg::QMin, vt_pkg::QMin, vt_pkg::QMin, 1'b1);
    queue_point(32'd1, 32'd0, 32'd0, 1'b1);
    queue_random(60);
    drain();
    m = '{default: vt_pkg::QMin};
    load_matrix(m);
    queue_point(vt_pkg::QMin, vt_pkg::QMin, vt_pkg::QMin, 1'b0);
    queue_point(vt_pkg::QMax, vt_pkg::QMax, vt_pkg::QMax, 1'b1);
    queue_random(60);
    drain();

    // Random matrices with random points.
    for (int phase = 0; phase < 6; phase++) begin
      for (int i = 0; i < 16; i++) m[i] = rand_elem();
      // In phase 2 the w column is zero, so every divide hits a zero w.
      if (phase == 2) begin
        m[3] = 0; m[7] = 0; m[11] = 0; m[15] = 0;
      end
      if (phase == 5) no_idling = 1'b1;
      load_matrix(m);
      queue_random(110);
      drain();
    end

    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/vt_pkg.sv
hdl/vertex_transform_4x4.sv
test/vertex_transform_4x4_test.sv
